FILE: rtl/core/fra_pkg.sv
// Shared types and constants for the fraction arithmetic and reduction block.
`timescale 1ns / 1ps

package fra_pkg;

    localparam int OPCODE_W  = 2;
    localparam int FIELD_W   = 16;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 32;

    localparam logic [OPCODE_W-1:0] OP_ADD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SUB = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MUL = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_DIV = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNDEF = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
    } in_t;

    typedef struct packed {
        logic signed [RES_NUM_W-1:0] res_num;
        logic signed [RES_DEN_W-1:0] res_den;
        logic                        status;
    } out_t;

endpackage

FILE: rtl/core/fra_mul.sv
// Shared registered magnitude multiplier.
`timescale 1ns / 1ps

module fra_mul #(
    parameter int W = 16
) (
    input  logic           aclk,
    input  logic [W-1:0]   x,
    input  logic [W-1:0]   y,
    output logic [2*W-1:0] p
);

    logic [2*W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= {{W{1'b0}}, x} * {{W{1'b0}}, y};
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/fra_gcd.sv
// Iterative binary GCD unit, one subtract or shift per cycle.
`timescale 1ns / 1ps

module fra_gcd #(
    parameter int PW = 33
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [PW-1:0] a_in,
    input  logic [PW-1:0] b_in,
    output logic          done,
    output logic [PW-1:0] g
);

    localparam int KW = $clog2(PW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] a_reg, a_next;
    logic [PW-1:0] b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic [PW-1:0] g_reg, g_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        if (start) begin
            busy_next = 1'b1;
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
        end else if (busy_reg) begin
            if (a_reg == '0) begin
                g_next    = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (b_reg == '0) begin
                g_next    = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!a_reg[0] && !b_reg[0]) begin
                // common factor of two: strip it and count it
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_reg >= b_reg) begin
                a_next = (a_reg - b_reg) >> 1;
            end else begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

FILE: rtl/core/fra_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fra_div #(
    parameter int PW = 33
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [PW-1:0] n_in,
    input  logic [PW-1:0] d_in,
    output logic          done,
    output logic [PW-1:0] q
);

    localparam int CW = $clog2(PW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [PW-1:0] quo_reg, quo_next;
    logic [PW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW:0]   shifted;
    logic [PW:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg, quo_reg[PW-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start) begin
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = n_in;
            d_next    = d_in;
            cnt_next  = CW'(PW);
        end else if (busy_reg) begin
            // dividend bits shift out the top while quotient bits shift in below
            if (!trial[PW]) begin
                rem_next = trial[PW-1:0];
                quo_next = {quo_reg[PW-2:0], 1'b1};
            end else begin
                rem_next = shifted[PW-1:0];
                quo_next = {quo_reg[PW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign q    = quo_reg;

endmodule

FILE: rtl/core/fraction_arith_reduce.sv
// Top level: fraction add, subtract, multiply, divide with GCD reduction.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data (fra_pkg::in_t)
//  m_      | out       | m_valid / m_ready  | m_data (fra_pkg::out_t)
//
// One item at a time: a new item is taken only when the previous one has left the
// sequencer. Each item passes the shared multiplier, the binary GCD unit, and the bit-serial
// divider run once on the numerator and once on the denominator; a numerator and denominator
// both zero skip the divider and give an undefined result.
// Reset is synchronous, active low, and leaves the block idle with no result pending.
// A finished result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module fraction_arith_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fra_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output fra_pkg::out_t m_data
);

    localparam int W   = OPERAND_WIDTH;
    localparam int PW  = 2 * W + 1;
    localparam int FW  = fra_pkg::FIELD_W;
    localparam int NW  = fra_pkg::RES_NUM_W;
    localparam int DW  = fra_pkg::RES_DEN_W;
    localparam int XW  = ((PW > NW) ? PW : NW) + 1;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MA      = 4'd1;
    localparam logic [3:0] ST_MB      = 4'd2;
    localparam logic [3:0] ST_MC      = 4'd3;
    localparam logic [3:0] ST_SUM     = 4'd4;
    localparam logic [3:0] ST_GCD_GO  = 4'd5;
    localparam logic [3:0] ST_GCD_W   = 4'd6;
    localparam logic [3:0] ST_DN_GO   = 4'd7;
    localparam logic [3:0] ST_DN_W    = 4'd8;
    localparam logic [3:0] ST_DD_GO   = 4'd9;
    localparam logic [3:0] ST_DD_W    = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    logic [3:0] state_reg, state_next;

    // operands as sign and magnitude
    logic [fra_pkg::OPCODE_W-1:0] op_reg;
    logic [W-1:0] an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic         an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;

    logic [2*W-1:0] pa_reg, pb_reg;
    logic [PW-1:0]  num_mag_reg, den_mag_reg;
    logic           num_neg_reg, den_neg_reg;
    logic [PW-1:0]  qn_reg;
    logic           undef_reg;

    logic          m_valid_reg;
    fra_pkg::out_t out_reg;

    logic [W-1:0]   mul_x, mul_y;
    logic [2*W-1:0] prod;

    logic          gcd_done, div_done;
    logic [PW-1:0] gcd_g, div_q, div_n;

    logic [W-1:0] an_v, ad_v, bn_v, bd_v;
    logic [FW+W-1:0] an_x, ad_x, bn_x, bd_x;

    logic          sa, sb;
    logic [PW-1:0] ma, mb;
    logic          sum_neg;
    logic [PW-1:0] sum_mag;
    logic          den_neg_c;

    logic [XW-1:0] qn_x, qd_x, rn_x, rd_x;
    logic          load_out;

    // take the low OPERAND_WIDTH bits of each field
    assign an_x = {{W{1'b0}}, s_data.a_num};
    assign ad_x = {{W{1'b0}}, s_data.a_den};
    assign bn_x = {{W{1'b0}}, s_data.b_num};
    assign bd_x = {{W{1'b0}}, s_data.b_den};
    assign an_v = an_x[W-1:0];
    assign ad_v = ad_x[W-1:0];
    assign bn_v = bn_x[W-1:0];
    assign bd_v = bd_x[W-1:0];

    assign s_ready = (state_reg == ST_IDLE);

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            ST_MA: begin
                mul_x = an_mag_reg;
                mul_y = (op_reg == fra_pkg::OP_MUL) ? bn_mag_reg : bd_mag_reg;
            end
            ST_MB: begin
                mul_x = bn_mag_reg;
                mul_y = ad_mag_reg;
            end
            default: begin
                mul_x = ad_mag_reg;
                mul_y = (op_reg == fra_pkg::OP_DIV) ? bn_mag_reg : bd_mag_reg;
            end
        endcase
    end

    fra_mul #(.W(W)) u_mul (
        .aclk (aclk),
        .x    (mul_x),
        .y    (mul_y),
        .p    (prod)
    );

    // signed-magnitude sum of the two cross products (add, subtract); first product alone otherwise
    always_comb begin
        sa = (pa_reg != '0) &&
             (an_neg_reg ^ ((op_reg == fra_pkg::OP_MUL) ? bn_neg_reg : bd_neg_reg));
        sb = (pb_reg != '0) && (bn_neg_reg ^ ad_neg_reg ^ (op_reg == fra_pkg::OP_SUB));
        ma = {1'b0, pa_reg};
        mb = {1'b0, pb_reg};
        if (op_reg inside {fra_pkg::OP_ADD, fra_pkg::OP_SUB}) begin
            if (sa == sb) begin
                sum_neg = sa;
                sum_mag = ma + mb;
            end else if (ma >= mb) begin
                sum_neg = sa;
                sum_mag = ma - mb;
            end else begin
                sum_neg = sb;
                sum_mag = mb - ma;
            end
            if (sum_mag == '0) begin
                sum_neg = 1'b0;
            end
        end else begin
            sum_neg = sa;
            sum_mag = ma;
        end
        den_neg_c = (prod != '0) &&
                    (ad_neg_reg ^ ((op_reg == fra_pkg::OP_DIV) ? bn_neg_reg : bd_neg_reg));
    end

    fra_gcd #(.PW(PW)) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_GCD_GO),
        .a_in    (num_mag_reg),
        .b_in    (den_mag_reg),
        .done    (gcd_done),
        .g       (gcd_g)
    );

    assign div_n = (state_reg == ST_DD_GO) ? den_mag_reg : num_mag_reg;

    fra_div #(.PW(PW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   ((state_reg == ST_DN_GO) || (state_reg == ST_DD_GO)),
        .n_in    (div_n),
        .d_in    (gcd_g),
        .done    (div_done),
        .q       (div_q)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_MA;
            ST_MA:     state_next = ST_MB;
            ST_MB:     state_next = ST_MC;
            ST_MC:     state_next = ST_SUM;
            ST_SUM:    state_next = ST_GCD_GO;
            ST_GCD_GO: state_next = ST_GCD_W;
            ST_GCD_W: begin
                if (gcd_done) begin
                    state_next = (gcd_g == '0) ? ST_DONE : ST_DN_GO;
                end
            end
            ST_DN_GO:  state_next = ST_DN_W;
            ST_DN_W:   if (div_done) state_next = ST_DD_GO;
            ST_DD_GO:  state_next = ST_DD_W;
            ST_DD_W:   if (div_done) state_next = ST_DONE;
            ST_DONE:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // output values, negated where the sign calls for it
    assign qn_x = {{(XW-PW){1'b0}}, qn_reg};
    assign qd_x = {{(XW-PW){1'b0}}, div_q};
    assign rn_x = num_neg_reg ? (~qn_x + 1'b1) : qn_x;
    assign rd_x = den_neg_reg ? (~qd_x + 1'b1) : qd_x;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (s_valid && s_ready) begin
            op_reg     <= s_data.opcode;
            an_neg_reg <= an_v[W-1];
            ad_neg_reg <= ad_v[W-1];
            bn_neg_reg <= bn_v[W-1];
            bd_neg_reg <= bd_v[W-1];
            an_mag_reg <= an_v[W-1] ? (~an_v + 1'b1) : an_v;
            ad_mag_reg <= ad_v[W-1] ? (~ad_v + 1'b1) : ad_v;
            bn_mag_reg <= bn_v[W-1] ? (~bn_v + 1'b1) : bn_v;
            bd_mag_reg <= bd_v[W-1] ? (~bd_v + 1'b1) : bd_v;
        end
        if (state_reg == ST_MB) begin
            pa_reg <= prod;
        end
        if (state_reg == ST_MC) begin
            pb_reg <= prod;
        end
        if (state_reg == ST_SUM) begin
            num_mag_reg <= sum_mag;
            num_neg_reg <= sum_neg;
            den_mag_reg <= {1'b0, prod};
            den_neg_reg <= den_neg_c;
        end
        if (state_reg == ST_GCD_W && gcd_done) begin
            undef_reg <= (gcd_g == '0);
        end
        if (state_reg == ST_DN_W && div_done) begin
            qn_reg <= div_q;
        end
        if (load_out) begin
            if (undef_reg) begin
                out_reg.res_num <= '0;
                out_reg.res_den <= '0;
                out_reg.status  <= fra_pkg::STATUS_UNDEF;
            end else begin
                out_reg.res_num <= rn_x[NW-1:0];
                out_reg.res_den <= rd_x[DW-1:0];
                out_reg.status  <= fra_pkg::STATUS_OK;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: verif/tb_fraction_arith_reduce.sv
// Self-checking testbench for fraction_arith_reduce: directed table, then random items.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS   = 400;
    localparam int QUIET_TAIL     = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;

    localparam int OW = fra_pkg::OPCODE_W;
    localparam int FW = fra_pkg::FIELD_W;
    localparam int NW = fra_pkg::RES_NUM_W;
    localparam int DW = fra_pkg::RES_DEN_W;

    typedef struct {
        fra_pkg::in_t  stim;
        bit            typed;
        fra_pkg::out_t want;
    } row_t;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    fra_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    fra_pkg::out_t m_data;

    fra_pkg::out_t pending_results[$];
    row_t          dir_rows[$];
    int            mismatch_count;
    int            stall_left;
    int            idle_cycles;
    bit            quiet_phase;
    fra_pkg::out_t want;

    fraction_arith_reduce u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Exact cross products, then divide both sides by the GCD of magnitudes.
    function automatic fra_pkg::out_t reduce_fraction(fra_pkg::in_t d);
        longint        an, ad, bn, bd, num, den, gx, gy, t;
        fra_pkg::out_t r;
        an = longint'(d.a_num);
        ad = longint'(d.a_den);
        bn = longint'(d.b_num);
        bd = longint'(d.b_den);
        case (d.opcode)
            fra_pkg::OP_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            fra_pkg::OP_SUB: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            fra_pkg::OP_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        gx = (num < 0) ? -num : num;
        gy = (den < 0) ? -den : den;
        while (gx != 0) begin
            t  = gx;
            gx = gy % gx;
            gy = t;
        end
        if (gy == 0) begin
            r.res_num = '0;
            r.res_den = '0;
            r.status  = fra_pkg::STATUS_UNDEF;
        end else begin
            r.res_num = NW'(num / gy);
            r.res_den = DW'(den / gy);
            r.status  = fra_pkg::STATUS_OK;
        end
        return r;
    endfunction

    function automatic fra_pkg::in_t pack_item(logic [OW-1:0] op, int an, int ad, int bn,
                                               int bd);
        fra_pkg::in_t d;
        d.opcode = op;
        d.a_num  = FW'(an);
        d.a_den  = FW'(ad);
        d.b_num  = FW'(bn);
        d.b_den  = FW'(bd);
        return d;
    endfunction

    function automatic logic signed [FW-1:0] rand_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: return FW'($urandom());
            4, 5, 6: return FW'($urandom_range(0, 40) - 20);
            7: return {1'b1, {(FW-1){1'b0}}};
            8: return {1'b0, {(FW-1){1'b1}}};
            default: return FW'($urandom_range(0, 2) - 1);
        endcase
    endfunction

    task automatic add_row(fra_pkg::in_t d, bit typed, longint n, longint dn, logic st);
        row_t r;
        r.stim          = d;
        r.typed         = typed;
        r.want.res_num  = NW'(n);
        r.want.res_den  = DW'(dn);
        r.want.status   = st;
        dir_rows.push_back(r);
    endtask

    // Hold the item until taken, then queue its expected result.
    task automatic send_item(fra_pkg::in_t d, bit typed, fra_pkg::out_t fixed);
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(typed ? fixed : reduce_fraction(d));
    endtask

    // Drop valid for a random burst, or until every result is back.
    task automatic sender_pause(bit drain);
        if (drain) begin
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge aclk);
        end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Result side: random stall bursts; no new burst starts in the quiet tail.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: res_num %0d res_den %0d status %0d",
                       m_data.res_num, m_data.res_den, m_data.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.res_num !== want.res_num) begin
                    $error("res_num: expected %0d, got %0d", want.res_num, m_data.res_num);
                    mismatch_count++;
                end
                if (m_data.res_den !== want.res_den) begin
                    $error("res_den: expected %0d, got %0d", want.res_den, m_data.res_den);
                    mismatch_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        fra_pkg::in_t d;
        mismatch_count = 0;
        stall_left     = 0;
        idle_cycles    = 0;
        quiet_phase    = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;

        // Typed rows: results readable at a glance.
        add_row(pack_item(fra_pkg::OP_ADD, 0, 0, 0, 0), 1, 0, 0, fra_pkg::STATUS_UNDEF);
        add_row(pack_item(fra_pkg::OP_ADD, 1, 1, 1, 1), 1, 2, 1, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_MUL, -32768, -32768, -32768, -32768), 1, 1, 1,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_MUL, 0, 5, 3, 7), 1, 0, 1, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_MUL, 0, -5, 1, 1), 1, 0, -1, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_MUL, 1, -3, 1, 1), 1, 1, -3, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_DIV, 1, 1, 0, 1), 1, 1, 0, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_DIV, -1, 1, 0, 1), 1, -1, 0, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_SUB, 3, 4, 3, 4), 1, 0, 1, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_SUB, 0, 0, 0, 0), 1, 0, 0, fra_pkg::STATUS_UNDEF);
        add_row(pack_item(fra_pkg::OP_MUL, 32767, 1, 32767, 1), 1, 1073676289, 1,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_ADD, -32768, 1, -32768, 1), 1, -65536, 1,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_DIV, 2, 3, 4, 5), 1, 5, 6, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_MUL, 5, 0, 0, 7), 1, 0, 0, fra_pkg::STATUS_UNDEF);
        // Mixed extremes, checked by the predictor.
        add_row(pack_item(fra_pkg::OP_SUB, 32767, -32768, -32768, 32767), 0, 0, 0,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_ADD, -32768, -32767, -32768, -32767), 0, 0, 0,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_DIV, -32768, 32767, 32767, -32768), 0, 0, 0,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_ADD, 32767, 32767, 32767, -32768), 0, 0, 0,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_MUL, -1, -1, -1, -1), 0, 0, 0, fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_DIV, 0, -32768, -32768, 0), 0, 0, 0,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_SUB, -32768, -32768, 32767, -32768), 0, 0, 0,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_ADD, 21845, -21846, -21846, 21845), 0, 0, 0,
                fra_pkg::STATUS_OK);
        add_row(pack_item(fra_pkg::OP_SUB, -21846, 21845, 21845, -21846), 0, 0, 0,
                fra_pkg::STATUS_OK);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
            sender_pause(1'b0);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                quiet_phase = 1'b1;
            d.opcode = OW'($urandom_range(0, 3));
            d.a_num  = rand_operand();
            d.a_den  = rand_operand();
            d.b_num  = rand_operand();
            d.b_den  = rand_operand();
            send_item(d, 1'b0, '0);
            sender_pause(i == RANDOM_ITEMS / 3);
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
